// ===== rtl/core/qbf_pkg.sv =====
// Package for the quadratic Bezier flattener: widths, types and command structs.
package qbf_pkg;

  localparam int COORD_W   = 24;
  localparam int IDX_W     = 6;
  localparam int NUM_LANES = 2;
  localparam int NUM_OPS   = 3;
  localparam int WGT_W     = 2 * IDX_W;
  localparam int DEN_W     = 2 * IDX_W;
  localparam int PROD_W    = WGT_W + COORD_W;
  localparam int ACC_W     = PROD_W;
  localparam int REM_W     = ACC_W + 2;
  localparam int DV_W      = DEN_W + 1 + COORD_W - 1;
  localparam int DIV_STEPS = COORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int MAC_LAST  = NUM_OPS;

  localparam logic [IDX_W-1:0]   SEG_RESET  = IDX_W'(10);
  localparam logic [COORD_W-1:0] COORD_BIAS = {1'b1, {(COORD_W-1){1'b0}}};

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [WGT_W-1:0]   wgt_t;

  // Operand select for the multiply-accumulate pass.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CTRL  = 2'd1,
    OP_END   = 2'd2
  } qbf_op_e;

  typedef struct packed {
    logic    load;
    logic    wgt;
    logic    mul;
    qbf_op_e sel;
    logic    acc;
    logic    div_init;
    logic    div_step;
    logic    next_pt;
  } qbf_cmd_t;

  typedef struct packed {
    logic last;
  } qbf_stat_t;

endpackage

// ===== rtl/core/qbf_curve_if.sv =====
// Handshake interface that carries one curve word (three control points).
interface qbf_curve_if;
  import qbf_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t ctrl_x;
  coord_t ctrl_y;
  coord_t end_x;
  coord_t end_y;

  modport source (
    output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
    output ready
  );
endinterface

// ===== rtl/core/qbf_point_if.sv =====
// Handshake interface that carries one point word on the flattened curve.
interface qbf_point_if;
  import qbf_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  idx_t   point_index;
  logic   last_point;

  modport source (
    output valid, point_x, point_y, point_index, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_index, last_point,
    output ready
  );
endinterface

// ===== rtl/core/qbf_ctrl.sv =====
// Sequencer for the flattener: steps the datapath through weights, MAC, divide and output.
module qbf_ctrl import qbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  qbf_stat_t stat_i,
  output qbf_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WGT,
    ST_MAC,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.sel = OP_START;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WGT;
        end
      end
      ST_WGT: begin
        cmd_o.wgt = 1'b1;
        cnt_d     = '0;
        state_d   = ST_MAC;
      end
      ST_MAC: begin
        // Multiply in counts 0..2, accumulate the registered product in counts 1..3.
        cmd_o.mul = (cnt_q < CNT_W'(NUM_OPS));
        cmd_o.acc = (cnt_q != '0);
        case (cnt_q)
          CNT_W'(0): cmd_o.sel = OP_START;
          CNT_W'(1): cmd_o.sel = OP_CTRL;
          default:   cmd_o.sel = OP_END;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAC_LAST)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_pt = 1'b1;
            state_d       = ST_WGT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

endmodule

// ===== rtl/core/qbf_datapath.sv =====
// Datapath for the flattener: held points, Bernstein weights, MAC and restoring divider.
module qbf_datapath import qbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  qbf_cmd_t  cmd_i,
  input  idx_t      seg_i,
  input  coord_t    start_x_i,
  input  coord_t    start_y_i,
  input  coord_t    ctrl_x_i,
  input  coord_t    ctrl_y_i,
  input  coord_t    end_x_i,
  input  coord_t    end_y_i,
  output qbf_stat_t stat_o,
  output coord_t    point_x_o,
  output coord_t    point_y_o,
  output idx_t      point_index_o,
  output logic      last_point_o
);

  // Coordinates are held with the sign bit flipped so the blend is unsigned.
  coord_t             held_q [NUM_LANES][NUM_OPS];
  idx_t               s_q, i_q;
  wgt_t               w_q    [NUM_OPS];
  logic [DEN_W-1:0]   den_q;
  logic [PROD_W-1:0]  prod_q [NUM_LANES];
  logic [ACC_W-1:0]   acc_q  [NUM_LANES];
  logic [REM_W-1:0]   rem_q  [NUM_LANES];
  coord_t             quo_q  [NUM_LANES];
  logic [DV_W-1:0]    dv_q;

  idx_t s_eff;
  idx_t r_cur;
  wgt_t w_sel;

  assign s_eff = (seg_i == '0) ? IDX_W'(1) : seg_i;
  assign r_cur = s_q - i_q;

  always_comb begin
    case (cmd_i.sel)
      OP_START: w_sel = w_q[0];
      OP_CTRL:  w_sel = w_q[1];
      default:  w_sel = w_q[2];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= IDX_W'(1);
      i_q <= '0;
    end else if (cmd_i.load) begin
      s_q <= s_eff;
      i_q <= '0;
    end else if (cmd_i.next_pt) begin
      i_q <= i_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_q[0][0] <= start_x_i ^ COORD_BIAS;
      held_q[0][1] <= ctrl_x_i  ^ COORD_BIAS;
      held_q[0][2] <= end_x_i   ^ COORD_BIAS;
      held_q[1][0] <= start_y_i ^ COORD_BIAS;
      held_q[1][1] <= ctrl_y_i  ^ COORD_BIAS;
      held_q[1][2] <= end_y_i   ^ COORD_BIAS;
      den_q        <= DEN_W'(s_eff) * DEN_W'(s_eff);
    end
    if (cmd_i.wgt) begin
      w_q[0] <= WGT_W'(r_cur) * WGT_W'(r_cur);
      w_q[1] <= (WGT_W'(r_cur) * WGT_W'(i_q)) << 1;
      w_q[2] <= WGT_W'(i_q) * WGT_W'(i_q);
    end
    if (cmd_i.div_init) begin
      dv_q <= DV_W'({den_q, 1'b0}) << (COORD_W - 1);
    end else if (cmd_i.div_step) begin
      dv_q <= dv_q >> 1;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      if (cmd_i.mul) begin
        case (cmd_i.sel)
          OP_START: prod_q[l] <= PROD_W'(w_sel) * PROD_W'(held_q[l][0]);
          OP_CTRL:  prod_q[l] <= PROD_W'(w_sel) * PROD_W'(held_q[l][1]);
          default:  prod_q[l] <= PROD_W'(w_sel) * PROD_W'(held_q[l][2]);
        endcase
      end
      if (cmd_i.wgt) begin
        acc_q[l] <= '0;
      end else if (cmd_i.acc) begin
        acc_q[l] <= acc_q[l] + ACC_W'(prod_q[l]);
      end
      // Round to nearest: floor((2*num + den) / (2*den)), one quotient bit per step.
      if (cmd_i.div_init) begin
        rem_q[l] <= REM_W'({acc_q[l], 1'b0}) + REM_W'(den_q);
        quo_q[l] <= '0;
      end else if (cmd_i.div_step) begin
        if (rem_q[l] >= REM_W'(dv_q)) begin
          rem_q[l] <= rem_q[l] - REM_W'(dv_q);
          quo_q[l] <= {quo_q[l][COORD_W-2:0], 1'b1};
        end else begin
          quo_q[l] <= {quo_q[l][COORD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign stat_o.last   = (i_q == s_q);
  assign point_x_o     = quo_q[0] ^ COORD_BIAS;
  assign point_y_o     = quo_q[1] ^ COORD_BIAS;
  assign point_index_o = i_q;
  assign last_point_o  = (i_q == s_q);

endmodule

// ===== rtl/core/quad_bezier_flattener.sv =====
// Top level of the quadratic Bezier flattener: config register, sequencer and datapath.
//
//   Port                 Dir  Word / meaning
//   curve_i              in   start, control and end point (x, y), 24-bit signed Q.8
//   point_o              out  point x, y (24-bit signed Q.8), step index, last flag
//   segment_count_we_i   in   write strobe for the 6-bit segment count
//   segment_count_i      in   segment count data (0 acts as 1)
//
// Each point goes through the weight state, the multiply-accumulate, the divider load
// and the restoring divide of the 24-bit quotient, then an output state.
// A curve with S segments yields S+1 points.
// The divider makes one quotient bit per cycle for x and y together.
// Reset returns the sequencer to idle and the segment count to 10.
// A stalled output word holds, and no new curve is taken until the last point leaves.
module quad_bezier_flattener import qbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              segment_count_we_i,
  input  idx_t              segment_count_i,
  qbf_curve_if.sink         curve_i,
  qbf_point_if.source       point_o
);

  idx_t      seg_q;
  qbf_cmd_t  cmd;
  qbf_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEG_RESET;
    end else if (segment_count_we_i) begin
      seg_q <= segment_count_i;
    end
  end

  qbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (curve_i.valid),
    .in_ready_o  (curve_i.ready),
    .out_valid_o (point_o.valid),
    .out_ready_i (point_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  qbf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .seg_i         (seg_q),
    .start_x_i     (curve_i.start_x),
    .start_y_i     (curve_i.start_y),
    .ctrl_x_i      (curve_i.ctrl_x),
    .ctrl_y_i      (curve_i.ctrl_y),
    .end_x_i       (curve_i.end_x),
    .end_y_i       (curve_i.end_y),
    .stat_o        (stat),
    .point_x_o     (point_o.point_x),
    .point_y_o     (point_o.point_y),
    .point_index_o (point_o.point_index),
    .last_point_o  (point_o.last_point)
  );

  // A curve is never taken while a point word is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid |-> !curve_i.ready)
    else $error("curve accepted while a point is pending");

  // After the last point leaves, the block is ready for the next curve.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_o.valid && point_o.ready && point_o.last_point) |=> curve_i.ready)
    else $error("not ready after the last point");

  // Taking a curve starts the computation; nothing is offered in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (curve_i.valid && curve_i.ready) |=> (!curve_i.ready && !point_o.valid))
    else $error("accept did not start the computation");

  // A point that is not the last is followed by computation, not by a repeat.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_o.valid && point_o.ready && !point_o.last_point) |=> !point_o.valid)
    else $error("point word repeated");

endmodule
